@@ hw/rtl/rlf_pkg.sv @@
// Shared types, widths and codes for the RGB linear fade engine.
`timescale 1ns / 1ps

package rlf_pkg;

   localparam int COLOR_W  = 8;
   localparam int INDEX_W  = 16;
   localparam int IV_W     = 10;
   localparam int MS_W     = 16;
   localparam int REQ_W    = 2;
   localparam int CONF_W   = 2;
   localparam int CHANNELS = 3;

   localparam logic [IV_W-1:0] IV_RESET = 10'd20;

   typedef logic [COLOR_W-1:0] color_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_SET  = 2'd0,
      REQ_TICK = 2'd1,
      REQ_OFF  = 2'd2
   } req_code_type;

   typedef enum logic [CONF_W-1:0] {
      CONF_NONE     = 2'd0,
      CONF_SET_DONE = 2'd1,
      CONF_ABORTED  = 2'd2,
      CONF_OFF_DONE = 2'd3
   } confirm_type;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_RAMPING = 2'd1,
      MODE_STABLE  = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABORT_OUT,
      ST_SET_START,
      ST_CNT_DIV,
      ST_STEP_DIV,
      ST_TICK_MUL,
      ST_TICK_OUT,
      ST_DONE_OUT,
      ST_OFF_OUT
   } state_type;

endpackage

@@ hw/rtl/rlf_csr_if.sv @@
// Configuration write channel carrying the tick interval.
`timescale 1ns / 1ps

interface rlf_csr_if;
   logic                      valid;
   logic                      ready;
   logic [rlf_pkg::IV_W-1:0]  tick_interval_ms;

   modport source (output valid, output tick_interval_ms, input ready);
   modport sink (input valid, input tick_interval_ms, output ready);
endinterface

@@ hw/rtl/rlf_req_if.sv @@
// Request channel: set, tick and off transactions.
`timescale 1ns / 1ps

interface rlf_req_if;
   logic                         valid;
   logic                         ready;
   logic [rlf_pkg::REQ_W-1:0]    req_type;
   logic [rlf_pkg::COLOR_W-1:0]  target_red;
   logic [rlf_pkg::COLOR_W-1:0]  target_green;
   logic [rlf_pkg::COLOR_W-1:0]  target_blue;
   logic [rlf_pkg::MS_W-1:0]     ramp_ms;

   modport source (output valid, output req_type, output target_red, output target_green,
                   output target_blue, output ramp_ms, input ready);
   modport sink (input valid, input req_type, input target_red, input target_green,
                 input target_blue, input ramp_ms, output ready);
endinterface

@@ hw/rtl/rlf_rsp_if.sv @@
// Result channel: driven colour, LED write flag and confirmation.
`timescale 1ns / 1ps

interface rlf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rlf_pkg::COLOR_W-1:0]  out_red;
   logic [rlf_pkg::COLOR_W-1:0]  out_green;
   logic [rlf_pkg::COLOR_W-1:0]  out_blue;
   logic                         led_write;
   logic [rlf_pkg::CONF_W-1:0]   confirm;
   logic                         last;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output led_write, output confirm, output last, input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input led_write, input confirm, input last, output ready);
endinterface

@@ hw/rtl/rgb_linear_fade_engine_unit.sv @@
// Top level of the RGB linear fade engine: control sequencer, ramp state and result register.
// Channels: req_chan takes set, tick and off transactions; rsp_chan returns results;
// csr_chan writes the tick interval in milliseconds (always ready, zero acts as one).
// One request is worked at a time; req_chan.ready is high only while the sequencer idles,
// and a finished result waits in the output register without holding up the next request.
// Set request: a serial divider forms the tick count, then three serial dividers form the
// per-channel steps; a set during a ramp first emits the aborted result.
// Tick while ramping: three serial multipliers form step * index; the ramp result leaves
// once they finish, and on the last tick the set-done result follows it.
// Off request: one result. Other ticks and code 3 give none.
// Throughput is set by the serial divider and multiplier lanes, one bit per cycle, and by receiver stalls.
// Reset: synchronous; mode off, colour zero, interval 20 ms, no result pending.
// Receiver stall: a result holds on rsp_chan until taken; the sequencer waits for the
// output register before it emits the next one.
`timescale 1ns / 1ps

module rgb_linear_fade_engine_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   rlf_csr_if.sink     csr_chan,
   rlf_req_if.sink     req_chan,
   rlf_rsp_if.source   rsp_chan
);

   localparam int CW     = rlf_pkg::COLOR_W;
   localparam int NCH    = rlf_pkg::CHANNELS;
   localparam int IXW    = rlf_pkg::INDEX_W;
   localparam int MAG_W  = CW + FRAC_BITS;
   localparam int CNT_NW = rlf_pkg::MS_W + 1;

   rlf_pkg::state_type state_ff, state_in;
   rlf_pkg::mode_type  mode_ff, mode_in;

   logic [rlf_pkg::IV_W-1:0] iv_ff;
   logic [rlf_pkg::MS_W-1:0] ramp_ms_ff, ramp_ms_in;
   logic [CW-1:0]            current_ff [NCH];
   logic [CW-1:0]            current_in [NCH];
   logic [CW-1:0]            start_ff [NCH];
   logic [CW-1:0]            start_in [NCH];
   logic [CW-1:0]            goal_ff [NCH];
   logic [CW-1:0]            goal_in [NCH];
   logic [MAG_W-1:0]         step_mag_ff [NCH];
   logic [MAG_W-1:0]         step_mag_in [NCH];
   logic [NCH-1:0]           step_neg_ff, step_neg_in;
   logic [IXW-1:0]           index_ff, index_in;
   logic [IXW-1:0]           total_ff, total_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]            rsp_color_ff [NCH];
   logic                     rsp_write_ff;
   logic [rlf_pkg::CONF_W-1:0] rsp_confirm_ff;
   logic                     rsp_last_ff;

   logic                     req_accept;
   logic                     slot_free;
   logic                     emit;
   logic [CW-1:0]            emit_color [NCH];
   logic                     emit_write;
   rlf_pkg::confirm_type     emit_confirm;
   logic                     emit_last;
   logic                     differs;

   logic [rlf_pkg::IV_W-1:0] iv_eff;
   logic [CNT_NW-1:0]        cnt_numer;
   logic [CNT_NW-1:0]        cnt_quot;
   logic                     cnt_done;
   logic                     cnt_start;
   logic [IXW-1:0]           cnt_value;

   logic                     step_start;
   logic [NCH-1:0]           step_done;
   logic [MAG_W-1:0]         step_numer [NCH];
   logic [MAG_W-1:0]         step_quot [NCH];
   logic [CW-1:0]            diff_mag [NCH];

   logic                     mul_start;
   logic [NCH-1:0]           mul_done;
   logic [MAG_W-1:0]         prod [NCH];
   logic [CW-1:0]            ramp_color [NCH];
   logic [CW:0]              fl_mag [NCH];
   logic [CW+2:0]            ramp_sum [NCH];

   assign req_accept       = req_chan.valid && req_chan.ready;
   assign req_chan.ready   = (state_ff == rlf_pkg::ST_IDLE);
   assign csr_chan.ready   = 1'b1;
   assign slot_free        = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      iv_eff    = (iv_ff == '0) ? rlf_pkg::IV_W'(1) : iv_ff;
      cnt_numer = CNT_NW'(ramp_ms_ff) + CNT_NW'(iv_eff) - CNT_NW'(1);
      cnt_value = (cnt_quot[IXW-1:0] == '0) ? IXW'(1) : cnt_quot[IXW-1:0];
      for (int c = 0; c < NCH; c++) begin
         diff_mag[c]   = (goal_ff[c] >= start_ff[c]) ? goal_ff[c] - start_ff[c]
                                                     : start_ff[c] - goal_ff[c];
         step_numer[c] = {diff_mag[c], {FRAC_BITS{1'b0}}};
      end
   end

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         fl_mag[c] = {1'b0, prod[c][MAG_W-1:FRAC_BITS]};
         if (step_neg_ff[c]) begin
            fl_mag[c]   = fl_mag[c] + (CW+1)'(|prod[c][FRAC_BITS-1:0]);
            ramp_sum[c] = (CW+3)'(start_ff[c]) - (CW+3)'(fl_mag[c]);
         end else begin
            ramp_sum[c] = (CW+3)'(start_ff[c]) + (CW+3)'(fl_mag[c]);
         end
         priority if (ramp_sum[c][CW+2]) begin
            ramp_color[c] = '0;
         end else if (ramp_sum[c][CW+1:CW] != '0) begin
            ramp_color[c] = '1;
         end else begin
            ramp_color[c] = ramp_sum[c][CW-1:0];
         end
      end
   end

   rlf_div #(.NUM_W(CNT_NW), .DEN_W(rlf_pkg::IV_W)) u_cnt_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cnt_start),
      .numer  (cnt_numer),
      .denom  (iv_eff),
      .done   (cnt_done),
      .quot   (cnt_quot)
   );

   for (genvar g = 0; g < NCH; g++) begin : g_lane
      rlf_div #(.NUM_W(MAG_W), .DEN_W(IXW)) u_step_div (
         .clock  (clock),
         .reset  (reset),
         .start  (step_start),
         .numer  (step_numer[g]),
         .denom  (cnt_value),
         .done   (step_done[g]),
         .quot   (step_quot[g])
      );

      rlf_mul #(.MC_W(MAG_W), .MP_W(IXW)) u_ramp_mul (
         .clock  (clock),
         .reset  (reset),
         .start  (mul_start),
         .mcand  (step_mag_ff[g]),
         .mplier (index_ff),
         .done   (mul_done[g]),
         .prod   (prod[g])
      );
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      ramp_ms_in  = ramp_ms_ff;
      index_in    = index_ff;
      total_in    = total_ff;
      step_neg_in = step_neg_ff;
      for (int c = 0; c < NCH; c++) begin
         current_in[c]  = current_ff[c];
         start_in[c]    = start_ff[c];
         goal_in[c]     = goal_ff[c];
         step_mag_in[c] = step_mag_ff[c];
         emit_color[c]  = current_ff[c];
      end
      cnt_start    = 1'b0;
      step_start   = 1'b0;
      mul_start    = 1'b0;
      emit         = 1'b0;
      emit_write   = 1'b0;
      emit_confirm = rlf_pkg::CONF_NONE;
      emit_last    = 1'b1;
      differs      = 1'b0;
      for (int c = 0; c < NCH; c++) begin
         differs = differs || (current_ff[c] != goal_ff[c]);
      end

      unique case (state_ff)
         rlf_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_chan.req_type)
                  rlf_pkg::REQ_SET: begin
                     goal_in[0] = req_chan.target_red;
                     goal_in[1] = req_chan.target_green;
                     goal_in[2] = req_chan.target_blue;
                     for (int c = 0; c < NCH; c++) begin
                        start_in[c] = current_ff[c];
                     end
                     ramp_ms_in = req_chan.ramp_ms;
                     state_in   = (mode_ff == rlf_pkg::MODE_RAMPING) ? rlf_pkg::ST_ABORT_OUT
                                                                    : rlf_pkg::ST_SET_START;
                  end
                  rlf_pkg::REQ_TICK: begin
                     if (mode_ff == rlf_pkg::MODE_RAMPING) begin
                        mul_start = 1'b1;
                        state_in  = rlf_pkg::ST_TICK_MUL;
                     end
                  end
                  rlf_pkg::REQ_OFF: begin
                     state_in = rlf_pkg::ST_OFF_OUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rlf_pkg::ST_ABORT_OUT: begin
            if (slot_free) begin
               emit         = 1'b1;
               emit_confirm = rlf_pkg::CONF_ABORTED;
               state_in     = rlf_pkg::ST_SET_START;
            end
         end
         rlf_pkg::ST_SET_START: begin
            cnt_start = 1'b1;
            state_in  = rlf_pkg::ST_CNT_DIV;
         end
         rlf_pkg::ST_CNT_DIV: begin
            if (cnt_done) begin
               total_in   = cnt_value;
               step_start = 1'b1;
               state_in   = rlf_pkg::ST_STEP_DIV;
            end
         end
         rlf_pkg::ST_STEP_DIV: begin
            if (&step_done) begin
               for (int c = 0; c < NCH; c++) begin
                  step_mag_in[c] = step_quot[c];
                  step_neg_in[c] = (goal_ff[c] < start_ff[c]);
               end
               index_in = '0;
               mode_in  = rlf_pkg::MODE_RAMPING;
               state_in = rlf_pkg::ST_IDLE;
            end
         end
         rlf_pkg::ST_TICK_MUL: begin
            if (&mul_done) begin
               for (int c = 0; c < NCH; c++) begin
                  current_in[c] = ramp_color[c];
               end
               index_in = index_ff + IXW'(1);
               state_in = rlf_pkg::ST_TICK_OUT;
            end
         end
         rlf_pkg::ST_TICK_OUT: begin
            if (slot_free) begin
               emit       = 1'b1;
               emit_write = 1'b1;
               emit_last  = (index_ff != total_ff);
               state_in   = (index_ff == total_ff) ? rlf_pkg::ST_DONE_OUT : rlf_pkg::ST_IDLE;
            end
         end
         rlf_pkg::ST_DONE_OUT: begin
            if (slot_free) begin
               emit         = 1'b1;
               emit_write   = differs;
               emit_confirm = rlf_pkg::CONF_SET_DONE;
               for (int c = 0; c < NCH; c++) begin
                  emit_color[c] = goal_ff[c];
                  current_in[c] = goal_ff[c];
               end
               mode_in  = rlf_pkg::MODE_STABLE;
               state_in = rlf_pkg::ST_IDLE;
            end
         end
         rlf_pkg::ST_OFF_OUT: begin
            if (slot_free) begin
               emit         = 1'b1;
               emit_write   = (mode_ff != rlf_pkg::MODE_OFF);
               emit_confirm = rlf_pkg::CONF_OFF_DONE;
               for (int c = 0; c < NCH; c++) begin
                  emit_color[c] = '0;
                  current_in[c] = '0;
               end
               mode_in  = rlf_pkg::MODE_OFF;
               state_in = rlf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlf_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlf_pkg::ST_IDLE;
         mode_ff      <= rlf_pkg::MODE_OFF;
         iv_ff        <= rlf_pkg::IV_RESET;
         rsp_valid_ff <= 1'b0;
         index_ff     <= '0;
         total_ff     <= '0;
         step_neg_ff  <= '0;
         for (int c = 0; c < NCH; c++) begin
            current_ff[c]  <= '0;
            start_ff[c]    <= '0;
            goal_ff[c]     <= '0;
            step_mag_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         index_ff     <= index_in;
         total_ff     <= total_in;
         step_neg_ff  <= step_neg_in;
         for (int c = 0; c < NCH; c++) begin
            current_ff[c]  <= current_in[c];
            start_ff[c]    <= start_in[c];
            goal_ff[c]     <= goal_in[c];
            step_mag_ff[c] <= step_mag_in[c];
         end
         if (csr_chan.valid) begin
            iv_ff <= csr_chan.tick_interval_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      ramp_ms_ff <= ramp_ms_in;
      if (emit) begin
         for (int c = 0; c < NCH; c++) begin
            rsp_color_ff[c] <= emit_color[c];
         end
         rsp_write_ff   <= emit_write;
         rsp_confirm_ff <= emit_confirm;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_red   = rsp_color_ff[0];
   assign rsp_chan.out_green = rsp_color_ff[1];
   assign rsp_chan.out_blue  = rsp_color_ff[2];
   assign rsp_chan.led_write = rsp_write_ff;
   assign rsp_chan.confirm   = rsp_confirm_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

@@ hw/rtl/rlf_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rlf_div #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = numer;
         rem_in = '0;
         den_in = denom;
      end else if (run_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

@@ hw/rtl/rlf_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module rlf_mul #(
   parameter int MC_W = 24,
   parameter int MP_W = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [MC_W-1:0] mcand,
   input  logic [MP_W-1:0] mplier,
   output logic            done,
   output logic [MC_W-1:0] prod
);

   localparam int CNT_W = $clog2(MP_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MC_W-1:0]  mcand_ff, mcand_in;
   logic [MP_W-1:0]  mplier_ff, mplier_in;
   logic [MC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         run_in    = 1'b1;
         cnt_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = '0;
      end else if (run_ff) begin
         cnt_in    = cnt_ff + CNT_W'(1);
         mplier_in = {mplier_ff[MP_W-2:0], 1'b0};
         acc_in    = {acc_ff[MC_W-2:0], 1'b0} + (mplier_ff[MP_W-1] ? mcand_ff : '0);
         if (cnt_ff == CNT_W'(MP_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ hw/rtl/rlf_checker.sv @@
// Port-level assertions for the RGB linear fade engine, bound to the top level.
`timescale 1ns / 1ps

module rlf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rlf_pkg::COLOR_W-1:0]  out_red,
   input logic [rlf_pkg::COLOR_W-1:0]  out_green,
   input logic [rlf_pkg::COLOR_W-1:0]  out_blue,
   input logic                         led_write,
   input logic [rlf_pkg::CONF_W-1:0]   confirm,
   input logic                         last
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({out_red, out_green, out_blue, led_write, confirm, last}))
      else $error("stalled result transaction changed");

   a_set_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && confirm == rlf_pkg::CONF_SET_DONE |-> last)
      else $error("set-done result not marked last");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && confirm == rlf_pkg::CONF_OFF_DONE
         |-> out_red == '0 && out_green == '0 && out_blue == '0 && last)
      else $error("off result carries a colour");

   a_ramp_writes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && confirm == rlf_pkg::CONF_NONE |-> led_write)
      else $error("ramp result without LED write");

endmodule

bind rgb_linear_fade_engine_unit rlf_checker u_rlf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_red   (rsp_chan.out_red),
   .out_green (rsp_chan.out_green),
   .out_blue  (rsp_chan.out_blue),
   .led_write (rsp_chan.led_write),
   .confirm   (rsp_chan.confirm),
   .last      (rsp_chan.last)
);

@@ dv/tb_rgb_linear_fade_engine_unit.sv @@
// Self-checking testbench for the RGB linear fade engine: directed table, then random phases.
`timescale 1ns / 1ps

module tb_rgb_linear_fade_engine_unit;

   localparam int FRAC           = 16;
   localparam int SETTLE_CYCLES  = 100;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 150;
   localparam logic [rlf_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [rlf_pkg::REQ_W-1:0]  kind;
      rlf_pkg::color_type [2:0]   tgt;
      logic [rlf_pkg::MS_W-1:0]   ms;
   } fade_req_type;

   typedef struct packed {
      rlf_pkg::color_type [2:0] rgb;
      logic                     wr;
      rlf_pkg::confirm_type     cf;
      logic                     last;
   } fade_result_type;

   typedef struct packed {
      fade_req_type    rq;
      logic            typed;
      fade_result_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rlf_csr_if csr_bus ();
   rlf_req_if req_bus ();
   rlf_rsp_if rsp_bus ();

   rgb_linear_fade_engine_unit #(
      .FRAC_BITS (FRAC)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_bus),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rlf_pkg::mode_type             lamp_mode;
   rlf_pkg::color_type            lamp_color [3];
   rlf_pkg::color_type            ramp_origin [3];
   rlf_pkg::color_type            ramp_goal [3];
   longint                        ramp_step [3];
   logic [rlf_pkg::INDEX_W-1:0]   ramp_pos;
   logic [rlf_pkg::INDEX_W-1:0]   ramp_len;
   logic [rlf_pkg::IV_W-1:0]      tick_ms;

   fade_result_type pending_results [$];
   int              errors = 0;
   int              phase_items = 0;
   int              stall_left = 0;
   int              hold_seq = 0;
   int              hold_seen = 0;
   bit              calm = 1'b0;

   function automatic fade_result_type lamp_result(logic wr, rlf_pkg::confirm_type cf,
                                                   logic last);
      fade_result_type r;
      for (int c = 0; c < rlf_pkg::CHANNELS; c++) r.rgb[c] = lamp_color[c];
      r.wr   = wr;
      r.cf   = cf;
      r.last = last;
      return r;
   endfunction

   function automatic rlf_pkg::color_type ramp_level(int c);
      longint s, mag, fl, v;
      s   = ramp_step[c];
      mag = ((s < 0) ? -s : s) * longint'(ramp_pos);
      if (s < 0) fl = -((mag + (longint'(1) <<< FRAC) - 1) >>> FRAC);
      else fl = mag >>> FRAC;
      v = longint'(ramp_origin[c]) + fl;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return rlf_pkg::color_type'(v);
   endfunction

   function automatic int predict_request(fade_req_type rq);
      int     n, iv, cnt, t, u;
      longint mag, q;
      logic   differs;
      n       = 0;
      differs = 1'b0;
      case (rq.kind)
         rlf_pkg::REQ_SET: begin
            if (lamp_mode == rlf_pkg::MODE_RAMPING) begin
               pending_results.push_back(lamp_result(1'b0, rlf_pkg::CONF_ABORTED, 1'b1));
               n = 1;
            end
            iv  = (tick_ms == '0) ? 1 : int'(tick_ms);
            cnt = (int'(rq.ms) + iv - 1) / iv;
            if (cnt == 0) cnt = 1;
            ramp_len = rlf_pkg::INDEX_W'(cnt);
            ramp_pos = '0;
            for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
               t   = rq.tgt[c];
               u   = lamp_color[c];
               mag = (t >= u) ? t - u : u - t;
               q   = (mag <<< FRAC) / cnt;
               ramp_step[c]   = (t >= u) ? q : -q;
               ramp_goal[c]   = rq.tgt[c];
               ramp_origin[c] = lamp_color[c];
            end
            lamp_mode = rlf_pkg::MODE_RAMPING;
         end
         rlf_pkg::REQ_TICK: begin
            if (lamp_mode == rlf_pkg::MODE_RAMPING) begin
               for (int c = 0; c < rlf_pkg::CHANNELS; c++) lamp_color[c] = ramp_level(c);
               ramp_pos = ramp_pos + 1'b1;
               if (ramp_pos != ramp_len) begin
                  pending_results.push_back(lamp_result(1'b1, rlf_pkg::CONF_NONE, 1'b1));
                  n = 1;
               end else begin
                  pending_results.push_back(lamp_result(1'b1, rlf_pkg::CONF_NONE, 1'b0));
                  for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
                     if (lamp_color[c] != ramp_goal[c]) differs = 1'b1;
                     lamp_color[c] = ramp_goal[c];
                  end
                  lamp_mode = rlf_pkg::MODE_STABLE;
                  pending_results.push_back(lamp_result(differs, rlf_pkg::CONF_SET_DONE, 1'b1));
                  n = 2;
               end
            end
         end
         rlf_pkg::REQ_OFF: begin
            differs = (lamp_mode != rlf_pkg::MODE_OFF);
            for (int c = 0; c < rlf_pkg::CHANNELS; c++) lamp_color[c] = '0;
            lamp_mode = rlf_pkg::MODE_OFF;
            pending_results.push_back(lamp_result(differs, rlf_pkg::CONF_OFF_DONE, 1'b1));
            n = 1;
         end
         default: begin
         end
      endcase
      return n;
   endfunction

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic rlf_pkg::color_type rand_level();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return rlf_pkg::color_type'($urandom_range(0, 255));
   endfunction

   function automatic fade_req_type make_req(logic [rlf_pkg::REQ_W-1:0] kind,
                                             rlf_pkg::color_type r, rlf_pkg::color_type g,
                                             rlf_pkg::color_type b,
                                             logic [rlf_pkg::MS_W-1:0] ms);
      fade_req_type rq;
      rq.kind   = kind;
      rq.tgt[0] = r;
      rq.tgt[1] = g;
      rq.tgt[2] = b;
      rq.ms     = ms;
      return rq;
   endfunction

   function automatic plan_row_type plan_entry(logic [rlf_pkg::REQ_W-1:0] kind,
                                               rlf_pkg::color_type r, rlf_pkg::color_type g,
                                               rlf_pkg::color_type b,
                                               logic [rlf_pkg::MS_W-1:0] ms, logic typed,
                                               rlf_pkg::color_type er, rlf_pkg::color_type eg,
                                               rlf_pkg::color_type eb, logic ewr,
                                               rlf_pkg::confirm_type ecf, logic elast);
      plan_row_type row;
      row.rq          = make_req(kind, r, g, b, ms);
      row.typed       = typed;
      row.want.rgb[0] = er;
      row.want.rgb[1] = eg;
      row.want.rgb[2] = eb;
      row.want.wr     = ewr;
      row.want.cf     = ecf;
      row.want.last   = elast;
      return row;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic send_request(fade_req_type rq, logic typed, fade_result_type want);
      int n;
      int g;
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= rq.kind;
      req_bus.target_red   <= rq.tgt[0];
      req_bus.target_green <= rq.tgt[1];
      req_bus.target_blue  <= rq.tgt[2];
      req_bus.ramp_ms      <= rq.ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n = predict_request(rq);
      if (typed && n > 0) pending_results[pending_results.size() - n] = want;
      if (rq.kind != REQ_UNUSED) phase_items++;
      g = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_plain(logic [rlf_pkg::REQ_W-1:0] kind, logic [rlf_pkg::MS_W-1:0] ms);
      send_request(make_req(kind, rand_level(), rand_level(), rand_level(), ms), 1'b0, '0);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(logic [rlf_pkg::IV_W-1:0] value);
      csr_bus.valid            <= 1'b1;
      csr_bus.tick_interval_ms <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      tick_ms = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(logic [rlf_pkg::IV_W-1:0] iv, bit quiet, bit squeeze);
      int pick, k, ticks, eff;
      settle();
      write_interval(iv);
      calm        <= quiet;
      phase_items  = 0;
      if (squeeze) hold_seq <= hold_seq + 1;
      eff = (iv == '0) ? 1 : int'(iv);
      while (phase_items < PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 6);
            send_plain(rlf_pkg::REQ_SET,
                       rlf_pkg::MS_W'((k - 1) * eff + $urandom_range(1, eff)));
            ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, k) : k;
            repeat (ticks) send_plain(rlf_pkg::REQ_TICK, rlf_pkg::MS_W'($urandom_range(0, 65535)));
         end else if (pick < 80) begin
            send_plain(rlf_pkg::REQ_OFF, rlf_pkg::MS_W'($urandom_range(0, 65535)));
         end else if (pick < 88) begin
            send_plain(rlf_pkg::REQ_TICK, rlf_pkg::MS_W'($urandom_range(0, 65535)));
         end else if (pick < 95) begin
            send_plain(rlf_pkg::REQ_SET, rlf_pkg::MS_W'($urandom_range(0, 65535)));
         end else begin
            send_plain(REQ_UNUSED, rlf_pkg::MS_W'($urandom_range(0, 65535)));
         end
      end
   endtask

   always @(posedge clock) begin : receiver
      fade_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %0d %0d %0d %0d %0d %0d",
                        $time, rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                        rsp_bus.led_write, rsp_bus.confirm, rsp_bus.last);
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("out_red", want.rgb[0], rsp_bus.out_red);
               check_field("out_green", want.rgb[1], rsp_bus.out_green);
               check_field("out_blue", want.rgb[2], rsp_bus.out_blue);
               check_field("led_write", want.wr, rsp_bus.led_write);
               check_field("confirm", int'(want.cf), rsp_bus.confirm);
               check_field("last", want.last, rsp_bus.last);
            end
         end
         if (hold_seq != hold_seen) begin
            hold_seen  = hold_seq;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 99) < 15) begin
            rsp_bus.ready <= 1'b0;
            stall_left = gap_len() - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      plan_row_type plan [$];
      csr_bus.valid            = 1'b0;
      csr_bus.tick_interval_ms = '0;
      req_bus.valid            = 1'b0;
      req_bus.req_type         = '0;
      req_bus.target_red       = '0;
      req_bus.target_green     = '0;
      req_bus.target_blue      = '0;
      req_bus.ramp_ms          = '0;
      rsp_bus.ready            = 1'b0;
      lamp_mode = rlf_pkg::MODE_OFF;
      for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
         lamp_color[c]  = '0;
         ramp_origin[c] = '0;
         ramp_goal[c]   = '0;
         ramp_step[c]   = 0;
      end
      ramp_pos = '0;
      ramp_len = '0;
      tick_ms  = rlf_pkg::IV_RESET;

      plan.push_back(plan_entry(rlf_pkg::REQ_OFF, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_OFF_DONE, 1'b1));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(REQ_UNUSED, 8'hFF, 8'h00, 8'hFF, 16'h1234, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
                                8'h00, 8'h00, 8'h00, 1'b1, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'h00, 8'h80, 8'hFF, 16'h0014, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
                                8'hFF, 8'hFF, 8'hFF, 1'b1, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_OFF, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
                                8'h00, 8'h00, 8'h00, 1'b1, rlf_pkg::CONF_OFF_DONE, 1'b1));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'hC8, 8'h64, 8'h32, 16'hFFFF, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
                                8'h00, 8'h00, 8'h00, 1'b1, rlf_pkg::CONF_NONE, 1'b1));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'h0A, 8'h14, 8'h1E, 16'h0028, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'h00, 8'h00, 8'h00, 16'h0001, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_OFF, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
                                8'h00, 8'h00, 8'h00, 1'b1, rlf_pkg::CONF_OFF_DONE, 1'b1));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'hAA, 8'h55, 8'hAA, 16'hAAAA, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_SET, 8'h55, 8'hAA, 8'h55, 16'h5555, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_NONE, 1'b0));
      plan.push_back(plan_entry(rlf_pkg::REQ_OFF, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1,
                                8'h00, 8'h00, 8'h00, 1'b1, rlf_pkg::CONF_OFF_DONE, 1'b1));
      plan.push_back(plan_entry(rlf_pkg::REQ_OFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1,
                                8'h00, 8'h00, 8'h00, 1'b0, rlf_pkg::CONF_OFF_DONE, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_request(plan[i].rq, plan[i].typed, plan[i].want);

      run_phase(10'd1, 1'b0, 1'b0);
      run_phase(10'd1000, 1'b0, 1'b0);
      run_phase(10'd0, 1'b1, 1'b1);
      run_phase(10'd1023, 1'b0, 1'b0);
      run_phase(rlf_pkg::IV_W'($urandom_range(2, 999)), 1'b0, 1'b0);
      run_phase(rlf_pkg::IV_RESET, 1'b0, 1'b0);
      settle();

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
